@@ rtl/rmps_pkg.sv @@
package rmps_pkg;

   // Width of the PWM phase counter.
   localparam int DUTY_BITS = 8;
   // Width used to compare the phase against an 8-bit duty level.
   localparam int CMP_W = (DUTY_BITS > 8) ? DUTY_BITS : 8;

   typedef logic [DUTY_BITS-1:0] phase_type;
   typedef logic [CMP_W-1:0]     cmp_type;

   // Movement modes.
   localparam logic [3:0] MODE_STOP       = 4'd0;
   localparam logic [3:0] MODE_FWD        = 4'd1;
   localparam logic [3:0] MODE_BACK       = 4'd2;
   localparam logic [3:0] MODE_TURN_FWD_L = 4'd3;
   localparam logic [3:0] MODE_TURN_FWD_R = 4'd4;
   localparam logic [3:0] MODE_TURN_BCK_L = 4'd5;
   localparam logic [3:0] MODE_TURN_BCK_R = 4'd6;
   localparam logic [3:0] MODE_ROT_L      = 4'd7;
   localparam logic [3:0] MODE_ROT_R      = 4'd8;

   // Drive codes for one motor pair.
   localparam logic [1:0] DRIVE_STOP = 2'd0;
   localparam logic [1:0] DRIVE_FWD  = 2'd1;
   localparam logic [1:0] DRIVE_REV  = 2'd2;

   // Strategy codes as reported on the result word.
   localparam logic [1:0] STRAT_ROAM   = 2'd0;
   localparam logic [1:0] STRAT_PUSH_F = 2'd1;
   localparam logic [1:0] STRAT_PUSH_B = 2'd2;
   localparam logic [1:0] STRAT_DONE   = 2'd3;

   localparam logic [7:0] ENDLESS    = 8'd255;
   localparam logic [7:0] FULL_SPEED = 8'd255;

   // Configuration register indexes.
   localparam logic [2:0] CSR_PUSH_RAMP_DURATION = 3'd0;
   localparam logic [2:0] CSR_PUSH_RAMP_SPEED    = 3'd1;
   localparam logic [2:0] CSR_ROTATE_DURATION    = 3'd2;
   localparam logic [2:0] CSR_ROTATE_SPEED       = 3'd3;
   localparam logic [2:0] CSR_BACKOFF_DURATION   = 3'd4;
   localparam logic [2:0] CSR_BACKOFF_SPEED      = 3'd5;

   typedef enum logic [3:0] {
      ST_ROAM   = 4'b0001,
      ST_PUSH_F = 4'b0010,
      ST_PUSH_B = 4'b0100,
      ST_DONE   = 4'b1000
   } strategy_type;

   typedef struct packed {
      logic [3:0] mode;
      logic [7:0] speed;
      logic [7:0] periods;
   } move_type;

   typedef struct packed {
      phase_type       phase;
      move_type [2:0]  plan;      // index 0 active, 1 next, 2 last
      strategy_type    strategy;
      logic [1:0]      drive_one;
      logic [1:0]      drive_two;
   } state_type;

   typedef struct packed {
      logic [7:0] push_ramp_duration;
      logic [7:0] push_ramp_speed;
      logic [7:0] rotate_duration;
      logic [7:0] rotate_speed;
      logic [7:0] backoff_duration;
      logic [7:0] backoff_speed;
   } cfg_type;

   typedef struct packed {
      logic line_front_left;
      logic line_front_right;
      logic line_back_left;
      logic line_back_right;
      logic bump_front;
      logic bump_back;
      logic stop_request;
   } sensor_type;

   typedef struct packed {
      logic [1:0] drive_pair_one;
      logic [1:0] drive_pair_two;
      logic [1:0] strategy_state;
      logic [3:0] active_mode;
   } result_type;

   function automatic logic [1:0] pattern_one(input logic [3:0] mode);
      logic [1:0] code;
      case (mode)
         MODE_FWD:        code = DRIVE_FWD;
         MODE_BACK:       code = DRIVE_REV;
         MODE_TURN_FWD_R: code = DRIVE_FWD;
         MODE_TURN_BCK_R: code = DRIVE_REV;
         MODE_ROT_L:      code = DRIVE_REV;
         MODE_ROT_R:      code = DRIVE_FWD;
         default:         code = DRIVE_STOP;
      endcase
      return code;
   endfunction

   function automatic logic [1:0] pattern_two(input logic [3:0] mode);
      logic [1:0] code;
      case (mode)
         MODE_FWD:        code = DRIVE_FWD;
         MODE_BACK:       code = DRIVE_REV;
         MODE_TURN_FWD_L: code = DRIVE_FWD;
         MODE_TURN_BCK_L: code = DRIVE_REV;
         MODE_ROT_L:      code = DRIVE_FWD;
         MODE_ROT_R:      code = DRIVE_REV;
         default:         code = DRIVE_STOP;
      endcase
      return code;
   endfunction

endpackage

@@ rtl/rmps_step.sv @@
// Next state of the sequencer for one word: a PWM tick or a strategy poll.
module rmps_step (
   input  rmps_pkg::state_type  state,
   input  rmps_pkg::cfg_type    cfg,
   input  logic                 func,
   input  rmps_pkg::sensor_type sensors,
   output rmps_pkg::state_type  state_in,
   output rmps_pkg::result_type result
);

   rmps_pkg::phase_type phase_nxt;
   logic [7:0]          periods_dec;
   logic                rotating;
   logic                line_fl;
   logic                line_fr;
   logic                line_bl;
   logic                line_br;

   assign phase_nxt   = state.phase + 1'b1;
   assign periods_dec = state.plan[0].periods - 8'd1;
   assign rotating    = (state.plan[0].mode == rmps_pkg::MODE_ROT_L) ||
                        (state.plan[0].mode == rmps_pkg::MODE_ROT_R);
   // Infrared levels are low when a line is under the sensor.
   assign line_fl = ~sensors.line_front_left;
   assign line_fr = ~sensors.line_front_right;
   assign line_bl = ~sensors.line_back_left;
   assign line_br = ~sensors.line_back_right;

   always_comb begin
      rmps_pkg::state_type nxt;
      nxt = state;
      if (!func) begin
         nxt.phase = phase_nxt;
         if ((phase_nxt == '0) && (state.plan[0].periods != rmps_pkg::ENDLESS)) begin
            if (periods_dec == 8'd0) begin
               nxt.plan[0] = state.plan[1];
               nxt.plan[1] = state.plan[2];
            end else begin
               nxt.plan[0].periods = periods_dec;
            end
         end
         if (rmps_pkg::cmp_type'(phase_nxt) <= rmps_pkg::cmp_type'(nxt.plan[0].speed)) begin
            nxt.drive_one = rmps_pkg::pattern_one(nxt.plan[0].mode);
            nxt.drive_two = rmps_pkg::pattern_two(nxt.plan[0].mode);
         end else begin
            nxt.drive_one = rmps_pkg::DRIVE_STOP;
            nxt.drive_two = rmps_pkg::DRIVE_STOP;
         end
      end else begin
         case (state.strategy)
            rmps_pkg::ST_ROAM: begin
               if (sensors.bump_front || sensors.bump_back) begin
                  nxt.strategy = sensors.bump_front ? rmps_pkg::ST_PUSH_F
                                                    : rmps_pkg::ST_PUSH_B;
                  nxt.plan[0].mode    = sensors.bump_front ? rmps_pkg::MODE_FWD
                                                           : rmps_pkg::MODE_BACK;
                  nxt.plan[0].speed   = cfg.push_ramp_speed;
                  nxt.plan[0].periods = cfg.push_ramp_duration;
                  nxt.plan[1].mode    = nxt.plan[0].mode;
                  nxt.plan[1].speed   = rmps_pkg::FULL_SPEED;
                  nxt.plan[1].periods = rmps_pkg::ENDLESS;
               end else if (!rotating && (line_fl || line_fr || line_bl || line_br)) begin
                  // Front lines rotate and back off in reverse, back lines rotate and go forward.
                  if (line_fl) begin
                     nxt.plan[0].mode = rmps_pkg::MODE_ROT_L;
                     nxt.plan[1].mode = rmps_pkg::MODE_BACK;
                  end else if (line_fr) begin
                     nxt.plan[0].mode = rmps_pkg::MODE_ROT_R;
                     nxt.plan[1].mode = rmps_pkg::MODE_BACK;
                  end else if (line_bl) begin
                     nxt.plan[0].mode = rmps_pkg::MODE_ROT_R;
                     nxt.plan[1].mode = rmps_pkg::MODE_FWD;
                  end else begin
                     nxt.plan[0].mode = rmps_pkg::MODE_ROT_L;
                     nxt.plan[1].mode = rmps_pkg::MODE_FWD;
                  end
                  nxt.plan[0].speed   = cfg.rotate_speed;
                  nxt.plan[0].periods = cfg.rotate_duration;
                  nxt.plan[1].speed   = cfg.backoff_speed;
                  nxt.plan[1].periods = cfg.backoff_duration;
                  nxt.plan[2].mode    = nxt.plan[1].mode;
                  nxt.plan[2].speed   = rmps_pkg::FULL_SPEED;
                  nxt.plan[2].periods = rmps_pkg::ENDLESS;
               end else if (sensors.stop_request) begin
                  nxt.strategy        = rmps_pkg::ST_DONE;
                  nxt.plan[0].mode    = rmps_pkg::MODE_STOP;
                  nxt.plan[0].periods = rmps_pkg::ENDLESS;
               end
            end
            rmps_pkg::ST_PUSH_F,
            rmps_pkg::ST_PUSH_B: begin
               if ((state.strategy == rmps_pkg::ST_PUSH_F) ? !sensors.bump_front
                                                           : !sensors.bump_back) begin
                  nxt.strategy      = rmps_pkg::ST_ROAM;
                  nxt.plan[0].speed = rmps_pkg::FULL_SPEED;
               end else if (sensors.stop_request) begin
                  nxt.strategy        = rmps_pkg::ST_DONE;
                  nxt.plan[0].mode    = rmps_pkg::MODE_STOP;
                  nxt.plan[0].periods = rmps_pkg::ENDLESS;
               end
            end
            default: begin
            end
         endcase
      end
      state_in = nxt;
   end

   always_comb begin
      result.drive_pair_one = state_in.drive_one;
      result.drive_pair_two = state_in.drive_two;
      result.active_mode    = state_in.plan[0].mode;
      case (state_in.strategy)
         rmps_pkg::ST_PUSH_F: result.strategy_state = rmps_pkg::STRAT_PUSH_F;
         rmps_pkg::ST_PUSH_B: result.strategy_state = rmps_pkg::STRAT_PUSH_B;
         rmps_pkg::ST_DONE:   result.strategy_state = rmps_pkg::STRAT_DONE;
         default:             result.strategy_state = rmps_pkg::STRAT_ROAM;
      endcase
   end

endmodule

@@ rtl/robot_motor_pwm_sequencer_unit.sv @@
// Motor PWM sequencer with a sumo strategy. Each request word is either a PWM tick
// (tuser low) or a sensor poll (tuser high); every word yields exactly one response
// word carrying both drive codes, the strategy state and the active movement mode.
// One word is taken per clock cycle and its response appears in the output register
// on the following cycle; the single registered pass from the held state through the
// step logic into the response register sets this figure. The request side stays
// ready while the response register is empty or is being emptied in the same cycle,
// so a steady stream runs at one word per cycle. Configuration is written through
// the csr_ port and should only be changed while no word is in flight.
module robot_motor_pwm_sequencer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: line_front_left, line_front_right, line_back_left,
   // line_back_right, bump_front, bump_back, stop_request, then zero fill.
   input  logic [7:0]  req_tdata,
   // Fields from bit 0: func (0 PWM tick, 1 sensor poll).
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: drive_pair_one[1:0], drive_pair_two[3:2],
   // strategy_state[5:4], active_mode[9:6], then zero fill.
   output logic [15:0] rsp_tdata,
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   rmps_pkg::state_type  state_ff;
   rmps_pkg::state_type  state_in;
   rmps_pkg::cfg_type    cfg_ff;
   rmps_pkg::sensor_type sensors;
   rmps_pkg::result_type result;
   logic                 rsp_valid_ff;
   logic [15:0]          rsp_data_ff;
   logic                 req_accept;

   // The response register frees up either when empty or when taken this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign sensors.line_front_left  = req_tdata[0];
   assign sensors.line_front_right = req_tdata[1];
   assign sensors.line_back_left   = req_tdata[2];
   assign sensors.line_back_right  = req_tdata[3];
   assign sensors.bump_front       = req_tdata[4];
   assign sensors.bump_back        = req_tdata[5];
   assign sensors.stop_request     = req_tdata[6];

   rmps_step u_step (
      .state    (state_ff),
      .cfg      (cfg_ff),
      .func     (req_tuser),
      .sensors  (sensors),
      .state_in (state_in),
      .result   (result)
   );

   // Sequencer state: plan of three movements, PWM phase, strategy and latched drive.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase           <= '0;
         state_ff.plan[0].mode    <= rmps_pkg::MODE_FWD;
         state_ff.plan[0].speed   <= rmps_pkg::FULL_SPEED;
         state_ff.plan[0].periods <= rmps_pkg::ENDLESS;
         state_ff.plan[1].mode    <= rmps_pkg::MODE_FWD;
         state_ff.plan[1].speed   <= rmps_pkg::FULL_SPEED;
         state_ff.plan[1].periods <= rmps_pkg::ENDLESS;
         state_ff.plan[2].mode    <= rmps_pkg::MODE_STOP;
         state_ff.plan[2].speed   <= rmps_pkg::FULL_SPEED;
         state_ff.plan[2].periods <= rmps_pkg::ENDLESS;
         state_ff.strategy        <= rmps_pkg::ST_ROAM;
         state_ff.drive_one       <= rmps_pkg::DRIVE_STOP;
         state_ff.drive_two       <= rmps_pkg::DRIVE_STOP;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Configuration registers; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.push_ramp_duration <= 8'd20;
         cfg_ff.push_ramp_speed    <= 8'd128;
         cfg_ff.rotate_duration    <= 8'd128;
         cfg_ff.rotate_speed       <= 8'd128;
         cfg_ff.backoff_duration   <= 8'd20;
         cfg_ff.backoff_speed      <= 8'd128;
      end else if (csr_wen) begin
         case (csr_index)
            rmps_pkg::CSR_PUSH_RAMP_DURATION: cfg_ff.push_ramp_duration <= csr_wdata;
            rmps_pkg::CSR_PUSH_RAMP_SPEED:    cfg_ff.push_ramp_speed    <= csr_wdata;
            rmps_pkg::CSR_ROTATE_DURATION:    cfg_ff.rotate_duration    <= csr_wdata;
            rmps_pkg::CSR_ROTATE_SPEED:       cfg_ff.rotate_speed       <= csr_wdata;
            rmps_pkg::CSR_BACKOFF_DURATION:   cfg_ff.backoff_duration   <= csr_wdata;
            rmps_pkg::CSR_BACKOFF_SPEED:      cfg_ff.backoff_speed      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Response register: valid is control, the data word needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= {6'd0, result.active_mode, result.strategy_state,
                         result.drive_pair_two, result.drive_pair_one};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
